@@ rtl/json_string_escaper_assert.svh @@
// Assertion macros used by the checker file.
`ifndef JSON_STRING_ESCAPER_ASSERT_SVH
`define JSON_STRING_ESCAPER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define JSE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define JSE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/jse_pkg.sv @@
package jse_pkg;

	// Configuration register indexes
	localparam logic CFG_REPLACE = 1'b0;
	localparam logic CFG_RAW     = 1'b1;

	// Characters
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_NUL    = 8'h00;

	// Control bytes with a short escape
	localparam logic [7:0] BY_BS = 8'h08;
	localparam logic [7:0] BY_HT = 8'h09;
	localparam logic [7:0] BY_LF = 8'h0A;
	localparam logic [7:0] BY_FF = 8'h0C;
	localparam logic [7:0] BY_CR = 8'h0D;

	// Kind of the middle part of an item's output
	typedef enum logic [2:0] {
		BODY_NONE,
		BODY_CHAR,
		BODY_PAIR,
		BODY_HEX,
		BODY_RAW
	} body_kind_t;

	// Classified item: open quote, '?' run, body, close quote, error result.
	// body_start/body_end/total are positions in the item's result list.
	typedef struct packed {
		logic             open;
		logic [2:0]       body_start;
		logic [3:0]       body_end;
		logic [3:0]       total;
		logic             err;
		body_kind_t       kind;
		logic [2:0]       cnt;      // hex digits or raw byte count
		logic [3:0][7:0]  bytes;
		logic [20:0]      cp;
	} item_desc_t;

	// Queue handshake between front and back
	typedef struct packed {
		logic full;
		logic head_valid;
	} q_status_t;

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] c;
		if (n < 4'd10) begin
			c = 8'h30 + {4'd0, n};
		end else begin
			c = 8'h37 + {4'd0, n};
		end
		return c;
	endfunction

endpackage

@@ rtl/json_string_escaper.sv @@
// Channel  | Handshake                  | Payload
// ---------+----------------------------+-------------------------------------
// input    | in_valid / in_stall        | data_byte, end_of_string, empty_string
// output   | out_valid / out_stall      | out_char, last, string_error
// config   | cfg_we, cfg_index          | cfg_data
//
// The front classifies one byte per cycle, unless the input is stalled, into
// an item descriptor; the back sends one character per cycle, unless the
// output is stalled, from a two-entry queue of descriptors. An item has up to
// 9 results, sent in order; the input stalls only while the queue holds two
// items. An item's first result passes the queue, then the output register.
// Reset clears string state, configuration, queue and output valid.
module json_string_escaper import jse_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_string,
	input  logic        empty_string,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_char,
	output logic        last,
	output logic        string_error
);

	item_desc_t push_desc, head;
	q_status_t  status;
	logic       push, pop, accept;

	assign in_stall = status.full;
	assign accept   = in_valid && !in_stall;

	jse_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.accept        (accept),
		.data_byte     (data_byte),
		.end_of_string (end_of_string),
		.empty_string  (empty_string),
		.push          (push),
		.desc          (push_desc)
	);

	jse_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.status    (status)
	);

	jse_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.status       (status),
		.pop          (pop),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.out_char     (out_char),
		.last         (last),
		.string_error (string_error)
	);

endmodule

@@ rtl/jse_front.sv @@
module jse_front import jse_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic        cfg_data,
	input  logic        accept,
	input  logic [7:0]  data_byte,
	input  logic        end_of_string,
	input  logic        empty_string,
	output logic        push,
	output item_desc_t  desc
);

	logic        replace_q, raw_q;
	logic        inside_q, discard_q;
	logic [7:0]  pend_q [3];
	logic [1:0]  pcnt_q;
	logic [2:0]  elen_q;
	logic [20:0] cp_q;

	logic        n_inside, n_discard;
	logic [1:0]  n_pcnt;
	logic [2:0]  n_elen;
	logic [20:0] n_cp;
	logic [2:0]  pend_we;
	logic        emit;

	// Classify one item and work out the next string state
	always_comb begin
		logic        ends, failed, handled, close, in_rng;
		logic [1:0]  pc;
		logic [2:0]  nq;
		logic [7:0]  lo, hi;
		logic [20:0] cpx;
		logic [3:0]  body_len;
		ends      = end_of_string | empty_string;
		failed    = 1'b0;
		handled   = 1'b0;
		close     = 1'b0;
		in_rng    = 1'b0;
		nq        = 3'd0;
		lo        = 8'h80;
		hi        = 8'hBF;
		cpx       = cp_q;
		body_len  = 4'd0;
		pc        = inside_q ? pcnt_q : 2'd0;
		n_inside  = inside_q;
		n_discard = discard_q;
		n_pcnt    = pcnt_q;
		n_elen    = elen_q;
		n_cp      = cp_q;
		pend_we   = 3'b000;
		emit      = 1'b0;
		desc      = '0;
		desc.kind = BODY_NONE;
		desc.open = !inside_q;
		desc.cnt  = 3'd4;
		desc.bytes[0] = data_byte;

		if (discard_q) begin
			// rejected string: swallow items up to its end
			if (ends) begin
				n_discard = 1'b0;
				n_inside  = 1'b0;
				n_pcnt    = 2'd0;
			end
		end else begin
			if (!empty_string) begin
				// continuation of a pending sequence
				if (pc != 2'd0) begin
					if (pc == 2'd1) begin
						case (pend_q[0])
							8'hE0:   lo = 8'hA0;
							8'hED:   hi = 8'h9F;
							8'hF0:   lo = 8'h90;
							8'hF4:   hi = 8'h8F;
							default: ;
						endcase
					end
					in_rng = (data_byte >= lo) && (data_byte <= hi);
					if (in_rng) begin
						handled = 1'b1;
						cpx     = {cp_q[14:0], data_byte[5:0]};
						n_cp    = cpx;
						if ({1'b0, pc} + 3'd1 >= elen_q) begin
							desc.cp       = cpx;
							desc.bytes[0] = pend_q[0];
							desc.bytes[1] = pend_q[1];
							desc.bytes[2] = pend_q[2];
							desc.bytes[pc] = data_byte;
							if (raw_q) begin
								desc.kind = BODY_RAW;
								desc.cnt  = {1'b0, pc} + 3'd1;
							end else begin
								desc.kind = BODY_HEX;
								desc.cnt  = cpx[20] ? 3'd6 : ((|cpx[19:16]) ? 3'd5 : 3'd4);
							end
							pc = 2'd0;
						end else begin
							pend_we = 3'b001 << pc;
							pc      = pc + 2'd1;
						end
					end else begin
						// broken sequence: flush what was buffered
						if (replace_q) begin
							nq = {1'b0, pc};
						end else begin
							failed = 1'b1;
						end
						pc = 2'd0;
					end
				end

				// fresh byte
				if (!handled && !failed) begin
					case (data_byte)
						BY_BS: begin desc.kind = BODY_PAIR; desc.bytes[0] = CH_B; end
						BY_FF: begin desc.kind = BODY_PAIR; desc.bytes[0] = CH_F; end
						BY_LF: begin desc.kind = BODY_PAIR; desc.bytes[0] = CH_N; end
						BY_CR: begin desc.kind = BODY_PAIR; desc.bytes[0] = CH_R; end
						BY_HT: begin desc.kind = BODY_PAIR; desc.bytes[0] = CH_T; end
						CH_SLASH, CH_QUOTE, CH_BSLASH: begin
							desc.kind = BODY_PAIR;
						end
						default: begin
							if (data_byte < 8'd32) begin
								if (replace_q) nq = nq + 3'd1;
								else failed = 1'b1;
							end else if (data_byte <= 8'd127) begin
								desc.kind = BODY_CHAR;
							end else if (data_byte >= 8'hC2 && data_byte <= 8'hDF) begin
								n_elen = 3'd2; n_cp = {16'd0, data_byte[4:0]};
								pend_we = 3'b001; pc = 2'd1;
							end else if (data_byte >= 8'hE0 && data_byte <= 8'hEF) begin
								n_elen = 3'd3; n_cp = {17'd0, data_byte[3:0]};
								pend_we = 3'b001; pc = 2'd1;
							end else if (data_byte >= 8'hF0 && data_byte <= 8'hF4) begin
								n_elen = 3'd4; n_cp = {18'd0, data_byte[2:0]};
								pend_we = 3'b001; pc = 2'd1;
							end else begin
								if (replace_q) nq = nq + 3'd1;
								else failed = 1'b1;
							end
						end
					endcase
				end
			end

			// end of string: flush a truncated sequence, then close
			if (!failed && ends) begin
				if (pc != 2'd0) begin
					if (replace_q) nq = nq + {1'b0, pc};
					else failed = 1'b1;
				end
				pc    = 2'd0;
				close = !failed;
			end

			if (ends || failed) begin
				n_inside = 1'b0;
				n_pcnt   = 2'd0;
			end else begin
				n_inside = 1'b1;
				n_pcnt   = pc;
			end
			if (failed && !ends) n_discard = 1'b1;
			if (failed) pend_we = 3'b000;

			// result list layout
			case (desc.kind)
				BODY_CHAR: body_len = 4'd1;
				BODY_PAIR: body_len = 4'd2;
				BODY_HEX:  body_len = 4'd2 + {1'b0, desc.cnt};
				BODY_RAW:  body_len = {1'b0, desc.cnt};
				default:   body_len = 4'd0;
			endcase
			desc.err        = failed;
			desc.body_start = {2'd0, desc.open} + nq;
			desc.body_end   = {1'b0, desc.body_start} + body_len;
			desc.total      = desc.body_end + {3'd0, close} + {3'd0, failed};
			emit = desc.total != 4'd0;
		end
	end

	assign push = accept && emit;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replace_q <= 1'b0;
			raw_q     <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_REPLACE) replace_q <= cfg_data;
			if (cfg_index == CFG_RAW)     raw_q     <= cfg_data;
		end
	end

	// String state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q  <= 1'b0;
			discard_q <= 1'b0;
			pcnt_q    <= 2'd0;
			elen_q    <= 3'd0;
			cp_q      <= '0;
		end else if (accept) begin
			inside_q  <= n_inside;
			discard_q <= n_discard;
			pcnt_q    <= n_pcnt;
			elen_q    <= n_elen;
			cp_q      <= n_cp;
		end
	end

	// Buffered sequence bytes
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (accept && pend_we[i]) pend_q[i] <= data_byte;
		end
	end

endmodule

@@ rtl/jse_queue.sv @@
module jse_queue import jse_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  item_desc_t  push_desc,
	input  logic        pop,
	output item_desc_t  head,
	output q_status_t   status
);

	item_desc_t  mem_q [2];
	logic        wr_q, rd_q;
	logic [1:0]  cnt_q;

	assign head              = mem_q[rd_q];
	assign status.full       = cnt_q == 2'd2;
	assign status.head_valid = cnt_q != 2'd0;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop)  rd_q <= !rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: ;
			endcase
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_desc;
	end

endmodule

@@ rtl/jse_back.sv @@
module jse_back import jse_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  item_desc_t  head,
	input  q_status_t   status,
	output logic        pop,
	input  logic        out_stall,
	output logic        out_valid,
	output logic [7:0]  out_char,
	output logic        last,
	output logic        string_error
);

	logic [3:0] pos_q;
	logic       out_valid_q, last_q, err_q;
	logic [7:0] char_q;
	logic       load, fin, is_err;
	logic [7:0] ch;

	assign load = status.head_valid && (!out_valid_q || !out_stall);
	assign fin  = pos_q == head.total - 4'd1;
	assign pop  = load && fin;

	// Character at the current position of the head item
	always_comb begin
		logic [2:0] j;
		logic [2:0] k;
		logic [3:0] nib;
		j      = 3'(pos_q - {1'b0, head.body_start});
		k      = 3'(head.cnt + 3'd1 - j);
		nib    = 4'd0;
		ch     = CH_QUOTE;
		is_err = 1'b0;
		case (k)
			3'd0:    nib = head.cp[3:0];
			3'd1:    nib = head.cp[7:4];
			3'd2:    nib = head.cp[11:8];
			3'd3:    nib = head.cp[15:12];
			3'd4:    nib = head.cp[19:16];
			3'd5:    nib = {3'd0, head.cp[20]};
			default: nib = 4'd0;
		endcase
		if (pos_q < {1'b0, head.body_start}) begin
			ch = (pos_q == 4'd0 && head.open) ? CH_QUOTE : CH_QMARK;
		end else if (pos_q < head.body_end) begin
			unique case (head.kind)
				BODY_CHAR: ch = head.bytes[0];
				BODY_PAIR: ch = (j == 3'd0) ? CH_BSLASH : head.bytes[0];
				BODY_RAW:  ch = head.bytes[j[1:0]];
				BODY_HEX: begin
					if (j == 3'd0)      ch = CH_BSLASH;
					else if (j == 3'd1) ch = CH_U;
					else                ch = hex_char(nib);
				end
				default:   ch = CH_QUOTE;
			endcase
		end else if (head.err && fin) begin
			ch     = CH_NUL;
			is_err = 1'b1;
		end
	end

	// Position within the head item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 4'd0;
		end else if (load) begin
			pos_q <= fin ? 4'd0 : pos_q + 4'd1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= ch;
			last_q <= fin;
			err_q  <= is_err;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_char     = char_q;
	assign last         = last_q;
	assign string_error = err_q;

endmodule

@@ rtl/jse_checker.sv @@
`include "json_string_escaper_assert.svh"

module jse_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_stall,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  out_char,
	input  logic        last,
	input  logic        string_error
);

	// a stalled result stays put
	`JSE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_char) && $stable(last) && $stable(string_error), "stalled result changed")

	// an error result is the item's last and carries a zero char
	`JSE_ASSERT_NOW(a_err_shape, out_valid && string_error, last && (out_char == 8'h00), "bad error result")

	// the queue only fills up behind a waiting result
	`JSE_ASSERT_NOW(a_full_out, in_stall, out_valid, "input stalled with no result pending")

endmodule

bind json_string_escaper jse_checker u_jse_checker (.*);
